### rtl/idti_pkg.sv
// ----------------------------------------------------------------------------
// idti_pkg: shared definitions of the infrared distance table interpolator
// Calibration tables, field widths, range status codes and the queue word.
// ----------------------------------------------------------------------------
package idti_pkg;

	// Table and field sizes.
	localparam int TABLE_POINTS = 14;
	localparam int SAMPLE_BITS  = 10;
	localparam int VAL_W        = 10;
	localparam int CM_W         = 7;
	localparam int SLOPE_W      = 8;
	localparam int SEG_W        = (TABLE_POINTS > 2) ? $clog2(TABLE_POINTS - 1) : 1;
	localparam int CNT_W        = $clog2(TABLE_POINTS + 1);
	localparam int CMP_W        = (SAMPLE_BITS > VAL_W) ? SAMPLE_BITS : VAL_W;
	localparam int IN_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = ((CM_W + 7) / 8) * 8;

	// Queue between the classifier and the divider pipeline.
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);

	typedef logic [VAL_W-1:0]   val_t;
	typedef logic [CM_W-1:0]    cm_t;
	typedef logic [SLOPE_W-1:0] slope_t;

	// Falling voltage curve and the matching distances in centimetres.
	localparam val_t VOLT_PTS [TABLE_POINTS] = '{
		10'd745, 10'd512, 10'd397, 10'd331, 10'd283, 10'd255, 10'd224,
		10'd200, 10'd188, 10'd171, 10'd164, 10'd151, 10'd116, 10'd110
	};
	localparam cm_t CM_PTS [TABLE_POINTS] = '{
		7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35, 7'd40,
		7'd45, 7'd50, 7'd55, 7'd60, 7'd65, 7'd70, 7'd75
	};
	// Integer slope of each segment: voltage step over centimetre step.
	localparam slope_t SLOPE_PTS [TABLE_POINTS-1] = '{
		8'd46, 8'd23, 8'd13, 8'd9, 8'd5, 8'd6, 8'd4,
		8'd2, 8'd3, 8'd1, 8'd2, 8'd7, 8'd1
	};

	// Range status carried with each result.
	typedef enum logic [1:0] {
		ST_IN_RANGE  = 2'd0,
		ST_TOO_CLOSE = 2'd1,
		ST_TOO_FAR   = 2'd2
	} status_t;

	// Classified word handed from the front to the back.
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic [SEG_W-1:0]       seg;
		status_t                status;
	} item_t;

endpackage

### rtl/idti_front.sv
// ----------------------------------------------------------------------------
// idti_front: sample classifier
// Finds the first table point that the sample reaches, and from it the
// segment and the range status of the word.
// ----------------------------------------------------------------------------
module idti_front
	import idti_pkg::*;
(
	input  logic [SAMPLE_BITS-1:0] sample,
	output item_t                  item
);

	logic [CNT_W-1:0] first;

	// Priority search for the first point at or below the sample.
	always_comb begin
		first = CNT_W'(TABLE_POINTS);
		for (int k = TABLE_POINTS - 1; k >= 0; k--) begin
			if (CMP_W'(sample) >= CMP_W'(VOLT_PTS[k])) begin
				first = CNT_W'(k);
			end
		end
	end

	// Saturating cases at either end of the curve, otherwise the segment below.
	always_comb begin
		item.sample = sample;
		if (first == '0) begin
			item.status = ST_TOO_CLOSE;
			item.seg    = '0;
		end else if (first == CNT_W'(TABLE_POINTS)) begin
			item.status = ST_TOO_FAR;
			item.seg    = '0;
		end else begin
			item.status = ST_IN_RANGE;
			item.seg    = SEG_W'(first - 1'b1);
		end
	end

endmodule

### rtl/idti_fifo.sv
// ----------------------------------------------------------------------------
// idti_fifo: short queue between classifier and divider
// Register-based first-in first-out buffer with a show-ahead read word.
// ----------------------------------------------------------------------------
module idti_fifo
	import idti_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t pop_item
);

	item_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;

	assign full      = (count_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### rtl/idti_back.sv
// ----------------------------------------------------------------------------
// idti_back: interpolation pipeline
// Looks up the segment constants, divides the voltage excess by the slope
// one quotient bit per stage and adds the segment distance.
// ----------------------------------------------------------------------------
module idti_back
	import idti_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  item_t           in_item,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CM_W-1:0] distance_cm,
	output logic [1:0]      range_status
);

	// Stage 0 is the lookup stage, stages 1 to VAL_W each settle one quotient bit.
	logic       pipe_vld_s [VAL_W+1];
	val_t       pipe_dd_s  [VAL_W+1];
	slope_t     pipe_rem_s [VAL_W+1];
	val_t       pipe_quo_s [VAL_W+1];
	slope_t     pipe_slp_s [VAL_W+1];
	cm_t        pipe_cm_s  [VAL_W+1];
	status_t    pipe_st_s  [VAL_W+1];

	slope_t     rem_next [VAL_W+1];
	val_t       quo_next [VAL_W+1];
	val_t       exc_in;
	logic [VAL_W:0] dist_sum;
	cm_t        dist_next;

	logic       out_valid_q;
	cm_t        dist_q;
	status_t    status_q;
	logic       en;

	// The whole pipeline moves whenever the output register can take a word.
	assign en  = !out_valid_q || out_ready;
	assign pop = en && in_valid;

	// Voltage excess above the sample in the chosen segment.
	assign exc_in = VAL_W'(CMP_W'(VOLT_PTS[in_item.seg]) - CMP_W'(in_item.sample));

	// Restoring division step of each stage.
	always_comb begin
		logic [SLOPE_W:0] trial;
		rem_next[0] = '0;
		quo_next[0] = '0;
		for (int k = 1; k <= VAL_W; k++) begin
			trial = {pipe_rem_s[k-1], pipe_dd_s[k-1][VAL_W-1]};
			if (trial >= {1'b0, pipe_slp_s[k-1]}) begin
				rem_next[k] = SLOPE_W'(trial - {1'b0, pipe_slp_s[k-1]});
				quo_next[k] = {pipe_quo_s[k-1][VAL_W-2:0], 1'b1};
			end else begin
				rem_next[k] = SLOPE_W'(trial);
				quo_next[k] = {pipe_quo_s[k-1][VAL_W-2:0], 1'b0};
			end
		end
	end

	// Final distance or saturated end value.
	assign dist_sum = (VAL_W + 1)'(pipe_quo_s[VAL_W]) + (VAL_W + 1)'(pipe_cm_s[VAL_W]);

	always_comb begin
		case (pipe_st_s[VAL_W])
			ST_IN_RANGE:  dist_next = CM_W'(dist_sum);
			ST_TOO_CLOSE: dist_next = CM_PTS[0];
			ST_TOO_FAR:   dist_next = CM_PTS[TABLE_POINTS-1];
			default:      dist_next = CM_PTS[0];
		endcase
	end

	// Valid flags of the stages and of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= VAL_W; k++) begin
				pipe_vld_s[k] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			pipe_vld_s[0] <= in_valid;
			for (int k = 1; k <= VAL_W; k++) begin
				pipe_vld_s[k] <= pipe_vld_s[k-1];
			end
			out_valid_q <= pipe_vld_s[VAL_W];
		end
	end

	// Payload of the stages and of the output register.
	always_ff @(posedge clk) begin
		if (en) begin
			pipe_dd_s[0]  <= exc_in;
			pipe_rem_s[0] <= rem_next[0];
			pipe_quo_s[0] <= quo_next[0];
			pipe_slp_s[0] <= SLOPE_PTS[in_item.seg];
			pipe_cm_s[0]  <= CM_PTS[in_item.seg];
			pipe_st_s[0]  <= in_item.status;
			for (int k = 1; k <= VAL_W; k++) begin
				pipe_dd_s[k]  <= {pipe_dd_s[k-1][VAL_W-2:0], 1'b0};
				pipe_rem_s[k] <= rem_next[k];
				pipe_quo_s[k] <= quo_next[k];
				pipe_slp_s[k] <= pipe_slp_s[k-1];
				pipe_cm_s[k]  <= pipe_cm_s[k-1];
				pipe_st_s[k]  <= pipe_st_s[k-1];
			end
			dist_q   <= dist_next;
			status_q <= pipe_st_s[VAL_W];
		end
	end

	assign out_valid    = out_valid_q;
	assign distance_cm  = dist_q;
	assign range_status = status_q;

endmodule

### rtl/ir_distance_table_interpolator.sv
// ----------------------------------------------------------------------------
// ir_distance_table_interpolator: infrared sensor sample to centimetres
// An accepted sample passes the queue, the lookup stage, the divider stages and the output register.
// Throughput: one sample per cycle through the pipelined divider, unless m_tready stalls the output.
// Reset clears the queue and all valid flags at once; no clearing pass.
// ----------------------------------------------------------------------------
module ir_distance_table_interpolator
	import idti_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] sample
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [6:0] distance_cm
	output logic [1:0]             m_tuser    // [1:0] range_status
);

	item_t           front_item;
	item_t           queue_item;
	logic            push;
	logic            pop;
	logic            full;
	logic            not_empty;
	logic [CM_W-1:0] distance_cm;

	// Accept a sample whenever the queue has room.
	assign s_tready = !full;
	assign push     = s_tvalid && s_tready;

	idti_front u_front (
		.sample (s_tdata[SAMPLE_BITS-1:0]),
		.item   (front_item)
	);

	idti_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_item  (queue_item)
	);

	idti_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (not_empty),
		.in_item      (queue_item),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.distance_cm  (distance_cm),
		.range_status (m_tuser)
	);

	assign m_tdata = OUT_TDATA_W'(distance_cm);

`ifndef SYNTHESIS
	// A stalled output must hold the pipeline, so nothing leaves the queue.
	a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !pop)
		else $error("queue popped while the output was stalled");

	// Too close results carry the nearest table distance.
	a_close_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_TOO_CLOSE) |-> (m_tdata[6:0] == CM_PTS[0]))
		else $error("too close result has the wrong distance");

	// Too far results carry the farthest table distance.
	a_far_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_TOO_FAR) |-> (m_tdata[6:0] == CM_PTS[TABLE_POINTS-1]))
		else $error("too far result has the wrong distance");

	// Interpolated results stay within the calibrated span, or at most one centimetre past its far end.
	a_range_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_IN_RANGE) |->
		(m_tdata[6:0] >= CM_PTS[0] && m_tdata[6:0] <= CM_PTS[TABLE_POINTS-1] + 1))
		else $error("interpolated distance out of the calibrated span");
`endif

endmodule

### dv/ir_distance_table_interpolator_tb.sv
// ----------------------------------------------------------------------------
// ir_distance_table_interpolator_tb: self-checking bench of the IR interpolator
// Sends raw sensor samples over the input stream and checks every distance and
// range status. A short directed table covers the saturation cases, the exact
// table hits and the bit extremes. Random samples follow, mostly inside the
// calibrated range and near the curve points. Both sides idle at random.
// ----------------------------------------------------------------------------
module ir_distance_table_interpolator_tb;
	import idti_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CURVE_N      = 14;
	localparam int RANDOM_ITEMS = 1526;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_MAX   = 10;

	// Calibration curve: falling converter readings and their distances in cm.
	localparam int CURVE_MV [CURVE_N] = '{
		745, 512, 397, 331, 283, 255, 224, 200, 188, 171, 164, 151, 116, 110
	};
	localparam int CURVE_CM [CURVE_N] = '{
		10, 15, 20, 25, 30, 35, 40, 45, 50, 55, 60, 65, 70, 75
	};

	typedef struct packed {
		cm_t     dist_cm;
		status_t status;
	} reading_t;

	// One directed row; the distance and status count only when fixed is set.
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		bit                     fixed;
		cm_t                    dist_cm;
		status_t                status;
	} probe_t;

	localparam int PROBE_N = 24;
	localparam probe_t PROBES [PROBE_N] = '{
		'{10'd1023, 1'b1, 7'd10, ST_TOO_CLOSE},
		'{10'd745,  1'b1, 7'd10, ST_TOO_CLOSE},
		'{10'd1000, 1'b1, 7'd10, ST_TOO_CLOSE},
		'{10'd744,  1'b0, 7'd0,  ST_IN_RANGE},
		'{10'd512,  1'b0, 7'd0,  ST_IN_RANGE},
		'{10'd511,  1'b0, 7'd0,  ST_IN_RANGE},
		'{10'd397,  1'b0, 7'd0,  ST_IN_RANGE},
		'{10'd300,  1'b0, 7'd0,  ST_IN_RANGE},
		'{10'd200,  1'b0, 7'd0,  ST_IN_RANGE},
		'{10'd188,  1'b0, 7'd0,  ST_IN_RANGE},
		'{10'd164,  1'b0, 7'd0,  ST_IN_RANGE},
		'{10'd151,  1'b0, 7'd0,  ST_IN_RANGE},
		'{10'd116,  1'b0, 7'd0,  ST_IN_RANGE},
		'{10'd111,  1'b0, 7'd0,  ST_IN_RANGE},
		'{10'd110,  1'b1, 7'd76, ST_IN_RANGE},
		'{10'd109,  1'b1, 7'd75, ST_TOO_FAR},
		'{10'd0,    1'b1, 7'd75, ST_TOO_FAR},
		'{10'd1,    1'b1, 7'd75, ST_TOO_FAR},
		'{10'd64,   1'b1, 7'd75, ST_TOO_FAR},
		'{10'd32,   1'b1, 7'd75, ST_TOO_FAR},
		'{10'd128,  1'b0, 7'd0,  ST_IN_RANGE},
		'{10'd256,  1'b0, 7'd0,  ST_IN_RANGE},
		'{10'd682,  1'b0, 7'd0,  ST_IN_RANGE},
		'{10'd341,  1'b0, 7'd0,  ST_IN_RANGE}
	};

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]             m_tuser;

	// Fixed expectation travelling alongside the word on the input bus.
	bit       word_fixed  = 1'b0;
	cm_t      word_dist   = '0;
	status_t  word_status = ST_IN_RANGE;

	reading_t pending_readings [$];
	int       error_count  = 0;
	int       idle_cycles  = 0;
	int       stall_left   = 0;
	int       calm_left    = 0;

	ir_distance_table_interpolator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Distance and status for one sample: segment search, then interpolation.
	function automatic reading_t predict_reading(logic [SAMPLE_BITS-1:0] smp);
		reading_t r;
		int       idx;
		int       seg;
		int       step_mv;
		int       step_cm;
		int       slope;
		idx = 0;
		while (idx < CURVE_N && int'(smp) < CURVE_MV[idx]) idx++;
		if (idx == 0) begin
			r.dist_cm = cm_t'(CURVE_CM[0]);
			r.status  = ST_TOO_CLOSE;
		end else if (idx >= CURVE_N) begin
			r.dist_cm = cm_t'(CURVE_CM[CURVE_N-1]);
			r.status  = ST_TOO_FAR;
		end else begin
			seg     = idx - 1;
			step_mv = CURVE_MV[seg] - CURVE_MV[idx];
			step_cm = CURVE_CM[idx] - CURVE_CM[seg];
			if (step_cm == 0) step_cm = 1;
			slope = (step_mv / step_cm) & 8'hFF;
			if (slope == 0) slope = 1;
			r.dist_cm = cm_t'((CURVE_MV[seg] - int'(smp)) / slope + CURVE_CM[seg]);
			r.status  = ST_IN_RANGE;
		end
		return r;
	endfunction

	// Idle length: mostly none, sometimes short, now and then long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 65) return 0;
		if (roll < 92) return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	// Random sample, weighted towards the calibrated span and the curve points.
	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		int roll;
		int k;
		roll = $urandom_range(99);
		if (roll < 55) return SAMPLE_BITS'($urandom_range(744, 110));
		if (roll < 80) begin
			k = $urandom_range(CURVE_N - 1);
			return SAMPLE_BITS'(CURVE_MV[k] + int'($urandom_range(2)) - 1);
		end
		return SAMPLE_BITS'($urandom_range(1023));
	endfunction

	task automatic note_error(input string msg);
		if (error_count < REPORT_MAX) $display("%t ERROR %s", $realtime, msg);
		error_count++;
	endtask

	// Present one sample and hold it until the block takes the word.
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input bit fixed,
			input cm_t exp_dist, input status_t status);
		s_tvalid    <= 1'b1;
		s_tdata     <= {{(IN_TDATA_W-SAMPLE_BITS){1'b0}}, smp};
		word_fixed  <= fixed;
		word_dist   <= exp_dist;
		word_status <= status;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and wait until every outstanding result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_readings.size() != 0) @(posedge clk);
	endtask

	// Receiver: random back-pressure with occasional stretches of none.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (calm_left > 0) calm_left <= calm_left - 1;
			else if ($urandom_range(99) < 3) calm_left <= $urandom_range(200, 40);
			else stall_left <= pick_gap();
		end
	end

	// Record the expected reading of each accepted input word.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			if (word_fixed) pending_readings.push_back('{word_dist, word_status});
			else pending_readings.push_back(predict_reading(s_tdata[SAMPLE_BITS-1:0]));
		end
	end

	// Compare each accepted output word with the oldest expectation.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_readings.size() == 0) begin
				note_error($sformatf("unexpected word dist=%0d status=%0d",
					m_tdata[CM_W-1:0], m_tuser));
			end else begin
				want = pending_readings.pop_front();
				if (m_tdata[CM_W-1:0] !== want.dist_cm || m_tuser !== want.status)
					note_error($sformatf("dist exp %0d got %0d, status exp %0d got %0d",
						want.dist_cm, m_tdata[CM_W-1:0], want.status, m_tuser));
			end
		end
	end

	// Watchdog: too many cycles in a row with no word moving on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("ir_distance_table_interpolator_tb: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus: reset, directed table, random samples, then drain and verdict.
	initial begin : stimulus
		int k;
		int gap;
		int calm_items;
		calm_items = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < PROBE_N; k++) begin
			send_sample(PROBES[k].sample, PROBES[k].fixed, PROBES[k].dist_cm,
				PROBES[k].status);
			gap = pick_gap();
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		drain_results();

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			send_sample(pick_sample(), 1'b0, '0, ST_IN_RANGE);
			// Halfway through, let the pipeline run empty once.
			if (k == RANDOM_ITEMS / 2) begin
				drain_results();
			end else begin
				if (calm_items > 0) begin
					gap = 0;
					calm_items--;
				end else if ($urandom_range(99) < 2) begin
					gap = 0;
					calm_items = $urandom_range(80, 30);
				end else begin
					gap = pick_gap();
				end
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("ir_distance_table_interpolator_tb: done, clean");
		end else begin
			$display("ir_distance_table_interpolator_tb: done, errors");
		end
		$finish;
	end

endmodule
